// File: rtl/core/bsc_pkg.sv
package bsc_pkg;

  localparam int DEF_SCALE_SHIFT = 19;

  localparam int RAW_W      = 24;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // width of one multiplicand slice in the wide products
  localparam int CHUNK_W = 24;

  localparam int OUT_DIV = 100;

  // divide by 100 as reciprocal multiply plus one correction step
  localparam int              QX_W        = 38;
  localparam int              RECIP_SHIFT = 44;
  localparam logic [QX_W-1:0] RECIP_100   = 38'd175921860444;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C0_C1   = 3'd0,
    REG_C00_C10 = 3'd1,
    REG_C01     = 3'd2,
    REG_C11     = 3'd3,
    REG_C20     = 3'd4,
    REG_C21     = 3'd5,
    REG_C30     = 3'd6
  } cfg_reg_t;

  function automatic logic [OUT_W-1:0] sat32(input logic neg, input logic [63:0] mag);
    logic [OUT_W-1:0] res;
    if (!neg) begin
      res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[OUT_W-1:0];
    end else begin
      res = (mag > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[OUT_W-1:0]);
    end
    return res;
  endfunction

endpackage

// File: rtl/core/baro_sensor_compensation.sv
// channel  dir  ports                                        word taken when
// input    in   start, busy, raw_temp, raw_press             start && !busy
// result   out  done, temp_centi, press_scaled               done (one cycle)
// config   in   cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// one input word per cycle while busy is low
// the pipeline holds the nested multiply chain and the divide-by-100 stages
// busy is high during reset and the cycle after it
// reset clears calibration registers and the pipeline valid bits
// no back-pressure: the pipeline never stalls
module baro_sensor_compensation #(
  parameter int SCALE_SHIFT = bsc_pkg::DEF_SCALE_SHIFT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [bsc_pkg::RAW_W-1:0]    raw_temp,
  input  logic signed [bsc_pkg::RAW_W-1:0]    raw_press,
  output logic                                done,
  output logic signed [bsc_pkg::OUT_W-1:0]    temp_centi,
  output logic signed [bsc_pkg::OUT_W-1:0]    press_scaled,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [bsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bsc_pkg::*;

  localparam int S   = SCALE_SHIFT;
  localparam int CW  = CHUNK_W;
  localparam int PW  = 2 * CW + 1;
  localparam int W1  = ((S + 17 > 40) ? S + 17 : 40) + 1;
  localparam int W2  = ((CW + W1 > 20 + 2 * S) ? CW + W1 : 20 + 2 * S) + 1;
  localparam int WN  = ((CW + W2 > 20 + 3 * S) ? CW + W2 : 20 + 3 * S) + 2;
  localparam int K1  = (W1 + CW - 1) / CW;
  localparam int K2  = (W2 + CW - 1) / CW;
  localparam int TSW = ((S + 12 > 36) ? S + 12 : 36) + 1;
  localparam int TNW = TSW + 7;
  localparam int HW  = QX_W / 2;
  localparam int MW  = HW + QX_W;
  localparam int SUMW = MW + HW;
  localparam int TD  = 6;
  localparam int LAT = 12;

  // calibration registers
  logic        [23:0] reg_c0c1;
  logic        [39:0] reg_c00c10;
  logic signed [15:0] reg_c01, reg_c11, reg_c20, reg_c21, reg_c30;

  logic signed [11:0] c0, c1, c0_half;
  logic signed [19:0] c00, c10;

  logic accept;
  logic [11:1] vld;

  // pipeline payload
  logic signed [39:0]     c30p1, c21p1;
  logic signed [35:0]     c1t1;
  logic signed [RAW_W-1:0] p1, t1, p2, t2, p3, t3, p4, t4;
  logic signed [W1-1:0]   a1_2, b1_2;
  logic signed [TSW-1:0]  tsum2;
  logic signed [PW-1:0]   pa3 [K1];
  logic signed [PW-1:0]   pb3 [K1];
  logic signed [TNW-1:0]  tn3;
  logic signed [W2-1:0]   a2_4, b2_4;
  logic                   tneg4;
  logic [TNW-S-1:0]       tmag4;
  logic signed [PW-1:0]   qa5 [K2];
  logic signed [PW-1:0]   qb5 [K2];
  logic [OUT_W-1:0]       temp5;
  logic signed [WN-1:0]   sp6, st6, n7;
  logic                   neg8, neg9, neg10, neg11;
  logic [QX_W-1:0]        x8, y9, y10;
  logic [MW-1:0]          mlo9, mhi9;
  logic [OUT_W-1:0]       qe10;
  logic [OUT_W:0]         q11;
  logic [OUT_W-1:0]       temp_dly [TD];

  // combinational helpers
  logic signed [K1*CW-1:0] a1_ext, b1_ext;
  logic signed [K2*CW-1:0] a2_ext, b2_ext;
  logic signed [CW:0]      a1_ch [K1];
  logic signed [CW:0]      b1_ch [K1];
  logic signed [CW:0]      a2_ch [K2];
  logic signed [CW:0]      b2_ch [K2];
  logic signed [TNW-1:0]   tsum_ext;
  logic [TNW-1:0]          tabs;
  logic signed [W2-1:0]    a2_sum, b2_sum;
  logic signed [WN-1:0]    sp_sum, st_sum;
  logic [WN-1:0]           nmag;
  logic [SUMW-1:0]         msum;
  logic [QX_W-1:0]         rem11;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_c0c1   <= '0;
      reg_c00c10 <= '0;
      reg_c01    <= '0;
      reg_c11    <= '0;
      reg_c20    <= '0;
      reg_c21    <= '0;
      reg_c30    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_C0_C1:   reg_c0c1   <= cfg_data[23:0];
        REG_C00_C10: reg_c00c10 <= cfg_data[39:0];
        REG_C01:     reg_c01    <= signed'(cfg_data[15:0]);
        REG_C11:     reg_c11    <= signed'(cfg_data[15:0]);
        REG_C20:     reg_c20    <= signed'(cfg_data[15:0]);
        REG_C21:     reg_c21    <= signed'(cfg_data[15:0]);
        REG_C30:     reg_c30    <= signed'(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  assign c0      = signed'(reg_c0c1[23:12]);
  assign c1      = signed'(reg_c0c1[11:0]);
  assign c0_half = c0 >>> 1;
  assign c00     = signed'(reg_c00c10[39:20]);
  assign c10     = signed'(reg_c00c10[19:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[10:1], accept};
      done <= vld[11];
    end
  end

  always_comb begin
    a1_ext = (K1 * CW)'(a1_2);
    b1_ext = (K1 * CW)'(b1_2);
    for (int j = 0; j < K1; j++) begin
      a1_ch[j] = signed'({(j == K1 - 1) ? a1_ext[j * CW + CW - 1] : 1'b0,
                          a1_ext[j * CW +: CW]});
      b1_ch[j] = signed'({(j == K1 - 1) ? b1_ext[j * CW + CW - 1] : 1'b0,
                          b1_ext[j * CW +: CW]});
    end
    a2_sum = W2'(c10) <<< (2 * S);
    b2_sum = W2'(reg_c01) <<< (2 * S);
    for (int j = 0; j < K1; j++) begin
      a2_sum = a2_sum + (W2'(pa3[j]) <<< (CW * j));
      b2_sum = b2_sum + (W2'(pb3[j]) <<< (CW * j));
    end
    a2_ext = (K2 * CW)'(a2_4);
    b2_ext = (K2 * CW)'(b2_4);
    for (int j = 0; j < K2; j++) begin
      a2_ch[j] = signed'({(j == K2 - 1) ? a2_ext[j * CW + CW - 1] : 1'b0,
                          a2_ext[j * CW +: CW]});
      b2_ch[j] = signed'({(j == K2 - 1) ? b2_ext[j * CW + CW - 1] : 1'b0,
                          b2_ext[j * CW +: CW]});
    end
    sp_sum = '0;
    st_sum = '0;
    for (int j = 0; j < K2; j++) begin
      sp_sum = sp_sum + (WN'(qa5[j]) <<< (CW * j));
      st_sum = st_sum + (WN'(qb5[j]) <<< (CW * j));
    end
    tsum_ext = TNW'(tsum2);
    tabs     = tn3[TNW-1] ? -tn3 : tn3;
    nmag     = n7[WN-1] ? -n7 : n7;
    msum     = SUMW'(mlo9) + (SUMW'(mhi9) << HW);
    rem11    = y10 - (QX_W'(qe10) * QX_W'(OUT_DIV));
  end

  always_ff @(posedge clk) begin
    // stage 1: first products
    c30p1 <= reg_c30 * raw_press;
    c21p1 <= reg_c21 * raw_press;
    c1t1  <= c1 * raw_temp;
    p1    <= raw_press;
    t1    <= raw_temp;
    // stage 2: inner nested terms
    a1_2  <= (W1'(reg_c20) <<< S) + W1'(c30p1);
    b1_2  <= (W1'(reg_c11) <<< S) + W1'(c21p1);
    tsum2 <= (TSW'(c0_half) <<< S) + TSW'(c1t1);
    p2    <= p1;
    t2    <= t1;
    // stage 3: sliced products by pressure, temperature times 100
    for (int j = 0; j < K1; j++) begin
      pa3[j] <= p2 * a1_ch[j];
      pb3[j] <= p2 * b1_ch[j];
    end
    tn3 <= (tsum_ext <<< 6) + (tsum_ext <<< 5) + (tsum_ext <<< 2);
    p3  <= p2;
    t3  <= t2;
    // stage 4: middle nested terms
    a2_4  <= a2_sum;
    b2_4  <= b2_sum;
    tneg4 <= tn3[TNW-1];
    tmag4 <= tabs[TNW-1:S];
    p4    <= p3;
    t4    <= t3;
    // stage 5: sliced products by pressure and temperature
    for (int j = 0; j < K2; j++) begin
      qa5[j] <= p4 * a2_ch[j];
      qb5[j] <= t4 * b2_ch[j];
    end
    temp5 <= sat32(tneg4, 64'(tmag4));
    // stage 6, 7: full numerator
    sp6 <= sp_sum;
    st6 <= st_sum;
    n7  <= (WN'(c00) <<< (3 * S)) + sp6 + st6;
    // stage 8: magnitude, drop fraction
    neg8 <= n7[WN-1];
    x8   <= QX_W'(nmag[WN-1:3*S]);
    // stage 9, 10: reciprocal multiply
    mlo9  <= x8[HW-1:0] * RECIP_100;
    mhi9  <= x8[QX_W-1:HW] * RECIP_100;
    y9    <= x8;
    neg9  <= neg8;
    qe10  <= msum[SUMW-1:RECIP_SHIFT];
    y10   <= y9;
    neg10 <= neg9;
    // stage 11: correction
    q11   <= (rem11 >= QX_W'(OUT_DIV)) ? (33'(qe10) + 33'd1) : 33'(qe10);
    neg11 <= neg10;
    // temperature delay line
    temp_dly[0] <= temp5;
    for (int j = 1; j < TD; j++) begin
      temp_dly[j] <= temp_dly[j-1];
    end
    // stage 12: output word
    temp_centi   <= signed'(temp_dly[TD-1]);
    press_scaled <= signed'(sat32(neg11, 64'(q11)));
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("result word missing after accepted input");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result word without matching input");

  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    vld[10] |-> (rem11 < QX_W'(2 * OUT_DIV)))
    else $error("divide-by-100 estimate out of range");

  a_busy_reset : assert property (@(posedge clk) disable iff (rst)
    busy |-> $past(rst))
    else $error("busy outside reset");

endmodule
